// ===== hdl/khvs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed hash variant selector package
// Word types, mixing constants and function codes shared by the design.
// ----------------------------------------------------------------------------
package khvs_pkg;

  localparam int HASH_W = 32;
  localparam int FRAC_W = 24;
  localparam int CHOICE_W = 8;
  localparam int KEY8_W = 8;

  // Function codes carried in the func field.
  localparam logic FUNC_CHOICE = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // Key mixing constants.
  localparam logic [HASH_W-1:0] MIX_HANDLE = 32'h9e37_79b9;
  localparam logic [HASH_W-1:0] MIX_PART   = 32'h85eb_ca6b;
  localparam logic [HASH_W-1:0] MIX_SEQ    = 32'hc2b2_ae35;
  localparam logic [HASH_W-1:0] MIX_SALT   = 32'h27d4_eb2d;

  // Finalizer multipliers.
  localparam logic [HASH_W-1:0] FIN_MUL_A  = 32'h7feb_352d;
  localparam logic [HASH_W-1:0] FIN_MUL_B  = 32'h846c_a68b;

  // Input word; the variant count travels beside it at its configured width.
  typedef struct packed {
    logic              func;
    logic [HASH_W-1:0] object_handle;
    logic [KEY8_W-1:0] part_index;
    logic [HASH_W-1:0] sequence_number;
    logic [KEY8_W-1:0] component_number;
  } in_word_t;

  typedef struct packed {
    logic [CHOICE_W-1:0] variant_choice;
    logic [FRAC_W-1:0]   sample_fraction;
    logic [HASH_W-1:0]   hash_word;
  } out_word_t;

  // Word handed from cell to cell along the remainder chain.
  typedef struct packed {
    logic              func;
    logic [HASH_W-1:0] hash;
    logic [HASH_W-1:0] num;
  } cell_word_t;

endpackage

// ===== hdl/khvs_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed hash pipeline
// Four stages: key mixing products, then the two multiply rounds of the
// finalizer, then the last xor-shift.
// ----------------------------------------------------------------------------
module khvs_hash import khvs_pkg::*; #(
  parameter int COUNT_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_word,
  input  logic [COUNT_BITS-1:0] in_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cell_word_t            out_word,
  output logic [COUNT_BITS-1:0] out_count
);

  logic v0_r, v1_r, v2_r, v3_r;
  logic ld0, ld1, ld2, ld3;

  logic [HASH_W-1:0] hk_r, p1_r, p2_r, p3_r;
  logic [HASH_W-1:0] m1_r, m2_r, h_r;
  logic func0_r, func1_r, func2_r, func3_r;
  logic [COUNT_BITS-1:0] cnt0_r, cnt1_r, cnt2_r, cnt3_r;

  logic [HASH_W-1:0] part_inc, seq_inc, salt, mix, mix_fold, m1_fold, m2_fold;

  // A stage loads when it is empty or its content moves on.
  assign ld3 = ~v3_r | out_ready;
  assign ld2 = ~v2_r | ld3;
  assign ld1 = ~v1_r | ld2;
  assign ld0 = ~v0_r | ld1;
  // Nothing is taken while reset is held.
  assign in_ready = ld0 & rst_n;

  always_comb begin
    part_inc = HASH_W'(in_word.part_index) + HASH_W'(1);
    seq_inc  = in_word.sequence_number + HASH_W'(1);
    salt     = (in_word.func == FUNC_SAMPLE) ?
               HASH_W'(in_word.component_number) + HASH_W'(1) : '0;
    mix      = hk_r ^ p1_r ^ p2_r ^ p3_r;
    mix_fold = mix ^ (mix >> 16);
    m1_fold  = m1_r ^ (m1_r >> 15);
    m2_fold  = m2_r ^ (m2_r >> 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ld0) v0_r <= in_valid;
      if (ld1) v1_r <= v0_r;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld0) begin
      hk_r    <= in_word.object_handle ^ MIX_HANDLE;
      p1_r    <= part_inc * MIX_PART;
      p2_r    <= seq_inc * MIX_SEQ;
      p3_r    <= salt * MIX_SALT;
      func0_r <= in_word.func;
      cnt0_r  <= in_count;
    end
    if (ld1) begin
      m1_r    <= mix_fold * FIN_MUL_A;
      func1_r <= func0_r;
      cnt1_r  <= cnt0_r;
    end
    if (ld2) begin
      m2_r    <= m1_fold * FIN_MUL_B;
      func2_r <= func1_r;
      cnt2_r  <= cnt1_r;
    end
    if (ld3) begin
      h_r     <= m2_fold;
      func3_r <= func2_r;
      cnt3_r  <= cnt2_r;
    end
  end

  assign out_valid     = v3_r;
  assign out_word.func = func3_r;
  assign out_word.hash = h_r;
  assign out_word.num  = h_r;
  assign out_count     = cnt3_r;

endmodule

// ===== hdl/khvs_mod_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remainder cell
// One restoring step of the hash modulo count: brings in the next dividend
// bit, subtracts the count when it fits and passes the word on.
// ----------------------------------------------------------------------------
module khvs_mod_cell import khvs_pkg::*; #(
  parameter int COUNT_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cell_word_t            in_word,
  input  logic [COUNT_BITS-1:0] in_count,
  input  logic [COUNT_BITS-1:0] in_rem,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cell_word_t            out_word,
  output logic [COUNT_BITS-1:0] out_count,
  output logic [COUNT_BITS-1:0] out_rem
);

  logic                  valid_r;
  cell_word_t            word_r, word_nxt;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [COUNT_BITS:0]   trial, diff;
  logic                  ld;

  assign ld = ~valid_r | out_ready;
  assign in_ready = ld;

  always_comb begin
    trial = {in_rem, in_word.num[HASH_W-1]};
    diff  = trial - {1'b0, in_count};
    if (trial >= {1'b0, in_count}) begin
      rem_nxt = diff[COUNT_BITS-1:0];
    end else begin
      rem_nxt = trial[COUNT_BITS-1:0];
    end
    word_nxt     = in_word;
    word_nxt.num = {in_word.num[HASH_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      word_r  <= word_nxt;
      count_r <= in_count;
      rem_r   <= rem_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;
  assign out_count = count_r;
  assign out_rem   = rem_r;

endmodule

// ===== hdl/keyed_hash_variant_selector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed hash variant selector
// Hashes object keys with a lowbias32 style finalizer and picks a variant
// by hash modulo count, or returns a 24-bit sample fraction.
// ----------------------------------------------------------------------------
// Pipeline: 4 hash stages, 32 remainder cells, 1 output register.
// Throughput: one word per cycle while out_ready does not stall the output;
// every stage moves on independently, so bubbles close up and input is
// taken while a finished word waits.
// Reset: synchronous, active low; clears all valid flags, the pipeline is
// empty and ready straight after reset. No clearing pass is needed.
// ----------------------------------------------------------------------------
module keyed_hash_variant_selector import khvs_pkg::*; #(
  parameter int COUNT_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  input  logic [COUNT_BITS-1:0] in_variant_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data
);

  // One cell per dividend bit of the hash.
  localparam int NUM_CELLS = HASH_W;

  // Chain links: index i feeds cell i, cell i drives index i+1.
  logic                  cv   [0:NUM_CELLS];
  logic                  crdy [0:NUM_CELLS];
  cell_word_t            cw   [0:NUM_CELLS];
  logic [COUNT_BITS-1:0] cc   [0:NUM_CELLS];
  logic [COUNT_BITS-1:0] cr   [0:NUM_CELLS];

  logic      out_valid_r;
  out_word_t out_data_r, out_data_nxt;
  logic      out_ld;
  logic [HASH_W-1:0] rem_wide;
  logic      count_zero;

  // The hash pipeline delivers the finalized word, which also seeds the
  // dividend that the remainder cells shift through.
  khvs_hash #(
    .COUNT_BITS (COUNT_BITS)
  ) u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_data),
    .in_count  (in_variant_count),
    .out_valid (cv[0]),
    .out_ready (crdy[0]),
    .out_word  (cw[0]),
    .out_count (cc[0])
  );

  // The partial remainder starts at zero for every word.
  assign cr[0] = '0;

  // Each cell retires one hash bit, most significant first. After the last
  // cell the remainder equals hash modulo count.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    khvs_mod_cell #(
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cv[i]),
      .in_ready  (crdy[i]),
      .in_word   (cw[i]),
      .in_count  (cc[i]),
      .in_rem    (cr[i]),
      .out_valid (cv[i+1]),
      .out_ready (crdy[i+1]),
      .out_word  (cw[i+1]),
      .out_count (cc[i+1]),
      .out_rem   (cr[i+1])
    );
  end

  // Output register: picks the fields that the function asks for. A zero
  // count gives choice zero, and the unused field of each function is zero.
  assign out_ld = ~out_valid_r | out_ready;
  assign crdy[NUM_CELLS] = out_ld;

  always_comb begin
    rem_wide   = HASH_W'(cr[NUM_CELLS]);
    count_zero = (cc[NUM_CELLS] == '0);
    out_data_nxt.hash_word = cw[NUM_CELLS].hash;
    if (cw[NUM_CELLS].func == FUNC_SAMPLE) begin
      out_data_nxt.variant_choice  = '0;
      out_data_nxt.sample_fraction = cw[NUM_CELLS].hash[FRAC_W-1:0];
    end else begin
      out_data_nxt.variant_choice  = count_zero ? '0 : rem_wide[CHOICE_W-1:0];
      out_data_nxt.sample_fraction = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= cv[NUM_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // All dividend bits have been shifted out by the end of the chain.
  a_dividend_spent: assert property (@(posedge clk) disable iff (!rst_n)
    cv[NUM_CELLS] |-> (cw[NUM_CELLS].num == '0))
    else $error("dividend bits left after the last remainder cell");

  // A nonzero count leaves a remainder below the count.
  a_rem_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cv[NUM_CELLS] && (cc[NUM_CELLS] != '0)) |-> (cr[NUM_CELLS] < cc[NUM_CELLS]))
    else $error("remainder not below variant count");

  // Only one of the two function fields can be nonzero.
  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.variant_choice == '0) || (out_data.sample_fraction == '0)))
    else $error("both choice and fraction are nonzero");

  // A nonzero fraction is always the low bits of the delivered hash.
  a_frac_from_hash: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.sample_fraction != '0)) |->
      (out_data.sample_fraction == out_data.hash_word[FRAC_W-1:0]))
    else $error("fraction does not match hash word");

endmodule

// ===== tb/keyed_hash_variant_selector_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed hash variant selector testbench
// Sends hash keys through the selector under random idling on both sides and
// checks the variant choice, sample fraction and full hash of every result
// word against a local computation of the same lowbias32 style hash.
// ----------------------------------------------------------------------------
module keyed_hash_variant_selector_test;
  import khvs_pkg::*;

  localparam int COUNT_BITS = 8;
  localparam int ITEMS_PER_PHASE = 284;
  // The pipeline is 37 stages deep; give it some slack before ending.
  localparam int DRAIN_CYCLES = 60;

  // A pending key word together with the variant count that rides beside it.
  typedef struct packed {
    in_word_t              key;
    logic [COUNT_BITS-1:0] count;
  } hash_request_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_data = '0;
  logic [COUNT_BITS-1:0] in_variant_count = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;

  // Keys waiting to be driven, and results owed by the block in order.
  hash_request_t keys_to_send[$];
  out_word_t     results_due[$];

  int  fault_count = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  // Set at each rising edge when the input word on the bus was taken.
  bit  word_taken = 1'b0;

  keyed_hash_variant_selector #(
    .COUNT_BITS(COUNT_BITS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .in_variant_count (in_variant_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Expected result word for one key. The key words are folded together with
  // odd multipliers (all products wrap at 32 bits), then the xor-shift-multiply
  // finalizer spreads the bits. The salt only enters for a repair sample.
  function automatic out_word_t select_variant(hash_request_t req);
    logic [HASH_W-1:0] v;
    logic [HASH_W-1:0] part_term;
    logic [HASH_W-1:0] seq_term;
    logic [HASH_W-1:0] salt;
    logic [HASH_W-1:0] count_wide;
    out_word_t         res;
    part_term = {24'd0, req.key.part_index} + 32'd1;
    seq_term = req.key.sequence_number + 32'd1;
    salt = (req.key.func == FUNC_SAMPLE) ? {24'd0, req.key.component_number} + 32'd1
                                         : 32'd0;
    count_wide = {{(HASH_W-COUNT_BITS){1'b0}}, req.count};
    v = req.key.object_handle ^ MIX_HANDLE;
    v = v ^ (part_term * MIX_PART);
    v = v ^ (seq_term * MIX_SEQ);
    v = v ^ (salt * MIX_SALT);
    v = v ^ (v >> 16);
    v = v * FIN_MUL_A;
    v = v ^ (v >> 15);
    v = v * FIN_MUL_B;
    v = v ^ (v >> 16);
    res = '0;
    res.hash_word = v;
    // Only one of the two narrow fields is live; the other stays zero.
    if (req.key.func == FUNC_SAMPLE) begin
      res.sample_fraction = v[FRAC_W-1:0];
    end else if (count_wide != 0) begin
      res.variant_choice = CHOICE_W'(v % count_wide);
    end
    return res;
  endfunction

  task automatic queue_key(input logic func, input logic [HASH_W-1:0] handle,
                           input logic [KEY8_W-1:0] part,
                           input logic [HASH_W-1:0] seq,
                           input logic [KEY8_W-1:0] comp,
                           input logic [COUNT_BITS-1:0] count);
    hash_request_t req;
    req.key.func = func;
    req.key.object_handle = handle;
    req.key.part_index = part;
    req.key.sequence_number = seq;
    req.key.component_number = comp;
    req.count = count;
    keys_to_send.push_back(req);
  endtask

  task automatic queue_random_keys(input int n);
    logic [HASH_W-1:0]     seq;
    logic [COUNT_BITS-1:0] count;
    for (int i = 0; i < n; i++) begin
      // Now and then push the sequence to its wrap point or the count to zero.
      seq = ($urandom_range(15) == 0) ? 32'hffff_ffff : $urandom;
      count = ($urandom_range(7) == 0) ? '0 : COUNT_BITS'($urandom_range(255));
      queue_key(($urandom_range(1) == 1) ? FUNC_SAMPLE : FUNC_CHOICE, $urandom,
                KEY8_W'($urandom_range(255)), seq, KEY8_W'($urandom_range(255)),
                count);
    end
  endtask

  // Driver: everything changes on the falling edge. A new word is only
  // presented once the previous one was taken, so valid never drops early.
  always @(negedge clk) begin : drive
    hash_request_t req;
    if (rst_n && (!in_valid || word_taken)) begin
      if (keys_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = keys_to_send.pop_front();
        in_valid <= 1'b1;
        in_data <= req.key;
        in_variant_count <= req.count;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: samples both handshakes at the rising edge. The output side is
  // checked before the input side is recorded, so a word accepted at this
  // edge can never be matched against a result that leaves at the same edge.
  always @(posedge clk) begin : watch
    out_word_t want;
    word_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result word %h arrived with nothing expected", $time, out_data);
          fault_count++;
        end else begin
          want = results_due.pop_front();
          if (out_data.variant_choice !== want.variant_choice) begin
            $display("%0t: variant_choice expected %0d actual %0d", $time,
                     want.variant_choice, out_data.variant_choice);
            fault_count++;
          end
          if (out_data.sample_fraction !== want.sample_fraction) begin
            $display("%0t: sample_fraction expected %h actual %h", $time,
                     want.sample_fraction, out_data.sample_fraction);
            fault_count++;
          end
          if (out_data.hash_word !== want.hash_word) begin
            $display("%0t: hash_word expected %h actual %h", $time,
                     want.hash_word, out_data.hash_word);
            fault_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        results_due.push_back(select_variant({in_data, in_variant_count}));
        word_taken = 1'b1;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      // Sender idles lightly while the receiver stalls hard, then the reverse,
      // then a stretch with no idling at all.
      case (phase)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 72;
        end
        1: begin
          send_idle_pct = 72;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      if (phase == 0) begin
        // Zero count gives choice zero; an all-zero key and a near all-one key.
        queue_key(FUNC_CHOICE, 32'h0, 8'd0, 32'h0, 8'd0, 8'd0);
        queue_key(FUNC_CHOICE, 32'hffff_ffff, 8'd255, 32'hffff_fffe, 8'd255, 8'd255);
        queue_key(FUNC_CHOICE, 32'hdead_beef, 8'd17, 32'h0000_1234, 8'd0, 8'd0);
        // Count of one always selects zero; small and full counts.
        queue_key(FUNC_CHOICE, 32'h1234_5678, 8'd3, 32'h0000_0042, 8'd9, 8'd1);
        queue_key(FUNC_CHOICE, 32'h1234_5678, 8'd3, 32'h0000_0042, 8'd9, 8'd2);
        queue_key(FUNC_CHOICE, 32'h1234_5678, 8'd3, 32'h0000_0042, 8'd9, 8'd255);
        queue_key(FUNC_CHOICE, 32'h8000_0001, 8'd128, 32'h7fff_ffff, 8'd128, 8'd128);
        // The sequence at its maximum wraps to zero inside the mix.
        queue_key(FUNC_CHOICE, 32'h0bad_cafe, 8'd1, 32'hffff_ffff, 8'd0, 8'd7);
        queue_key(FUNC_SAMPLE, 32'h0bad_cafe, 8'd1, 32'hffff_ffff, 8'd0, 8'd7);
        // The component only matters for a sample; same key, different salt.
        queue_key(FUNC_CHOICE, 32'h5555_aaaa, 8'd42, 32'h0000_0001, 8'd255, 8'd3);
        queue_key(FUNC_SAMPLE, 32'h5555_aaaa, 8'd42, 32'h0000_0001, 8'd255, 8'd3);
        queue_key(FUNC_SAMPLE, 32'h5555_aaaa, 8'd42, 32'h0000_0001, 8'd0, 8'd3);
        // Samples with zero and full counts must leave the choice at zero.
        queue_key(FUNC_SAMPLE, 32'h0, 8'd0, 32'h0, 8'd0, 8'd0);
        queue_key(FUNC_SAMPLE, 32'hffff_ffff, 8'd255, 32'hffff_ffff, 8'd255, 8'd255);
        queue_key(FUNC_SAMPLE, 32'haaaa_5555, 8'd254, 32'h8000_0000, 8'd254, 8'd200);
        queue_key(FUNC_CHOICE, 32'haaaa_5555, 8'd254, 32'h8000_0000, 8'd254, 8'd200);
      end
      queue_random_keys(ITEMS_PER_PHASE);

      while (keys_to_send.size() != 0 || in_valid || results_due.size() != 0) begin
        @(posedge clk);
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog well past the slowest legal run.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
